FILE: sv/tag_content_extractor_assert.svh
// Assertion macros for the tag content extractor.
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef TAG_CONTENT_EXTRACTOR_ASSERT_SVH
`define TAG_CONTENT_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define TCE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tag_content_extractor: assertion failed");

// Expression must never be true at a rising edge outside reset.
`define TCE_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tag_content_extractor: forbidden condition seen");

`else

`define TCE_ASSERT(name, clk, rst_n, prop)
`define TCE_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

FILE: sv/tce_pkg.sv
`default_nettype none

package tce_pkg;

    localparam int NUM_TAGS = 7;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] pos_t;
    typedef logic [NUM_TAGS-1:0] tag_mask_t;

    // Special characters of the markup stream.
    localparam byte_t CHAR_OPEN    = 8'h3C;
    localparam byte_t CHAR_CLOSE   = 8'h3E;
    localparam byte_t CHAR_NEWLINE = 8'h0A;

    localparam tag_mask_t MASK_RESET = '1;

    // Matcher phase.
    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_NAME = 2'd1
    } phase_t;

    // Tag name lengths in the order A, IMG, BASE, FORM, LINK, SCRIPT, IFRAME.
    localparam pos_t TAG_LEN [NUM_TAGS] = '{
        3'd1, 3'd3, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6
    };

    // Tag name letters, padded to eight positions so a 3-bit position
    // indexes the row directly.
    localparam byte_t TAG_TEXT [NUM_TAGS][8] = '{
        '{8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h4D, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h41, 8'h53, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h4F, 8'h52, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4C, 8'h49, 8'h4E, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h43, 8'h52, 8'h49, 8'h50, 8'h54, 8'h00, 8'h00},
        '{8'h49, 8'h46, 8'h52, 8'h41, 8'h4D, 8'h45, 8'h00, 8'h00}
    };

    // Byte held in the input register.
    typedef struct packed {
        byte_t data;
        logic  last;
    } in_item_t;

    // Result of one matcher step.
    typedef struct packed {
        logic  valid;
        byte_t data;
        logic  last;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/tag_content_extractor.sv
// Streaming extractor of the content that follows selected opening tags.
// Input channel: in_byte and end_of_input with in_valid/in_ready; one
// document byte per transaction, end_of_input set on the last byte.
// Output channel: out_byte and item_last with out_valid/out_ready; each
// transaction is one copied content byte, or a newline with item_last set
// that closes an item. Most input bytes produce no output transaction.
// Configuration: cfg_we writes cfg_data into the 7-bit tag enable mask
// (A, IMG, BASE, FORM, LINK, SCRIPT, IFRAME from bit 0); no wait states.
// Path: an accepted byte is loaded into the input register, and one matcher
// step moves its result into the output register once that register can
// take it.
// Throughput: one byte per cycle while the output register is not stalled;
// the matcher update between the input and output registers is combinational.
// Reset: the mask returns to all tags enabled, the matcher goes idle and
// both registers are emptied.
// Stall: while the output register holds an untaken result, the matcher
// stops; the input register keeps one byte and in_ready falls once it is
// full, so nothing is lost or repeated.
`default_nettype none

module tag_content_extractor
    import tce_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire tag_mask_t cfg_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire byte_t     in_byte,
    input  wire logic      end_of_input,
    output logic           out_valid,
    input  wire logic      out_ready,
    output byte_t          out_byte,
    output logic           item_last
);

    logic     out_take;
    logic     step;
    in_item_t item;
    result_t  result;

    tce_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_take     (out_take),
        .step         (step),
        .item         (item)
    );

    tce_matcher u_matcher (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (step),
        .item     (item),
        .result   (result)
    );

    tce_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_take  (out_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .item_last (item_last)
    );

endmodule

`default_nettype wire

FILE: sv/tce_in_stage.sv
`default_nettype none

module tce_in_stage
    import tce_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire byte_t    in_byte,
    input  wire logic     end_of_input,
    input  wire logic     out_take,
    output logic          step,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A held byte moves on whenever the output register can take its result.
    assign step     = valid_reg && out_take;
    assign in_ready = !valid_reg || step;
    assign item     = item_reg;

    // Input register occupancy.
    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload of each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data <= in_byte;
            item_reg.last <= end_of_input;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tce_matcher.sv
`default_nettype none

`include "tag_content_extractor_assert.svh"

module tce_matcher
    import tce_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire tag_mask_t cfg_data,
    input  wire logic      step,
    input  wire in_item_t  item,
    output result_t        result
);

    tag_mask_t mask_reg;
    phase_t    phase_reg;
    phase_t    phase_next;
    pos_t      pos_reg;
    pos_t      pos_next;
    tag_mask_t cand_reg;
    tag_mask_t cand_next;
    logic      content_reg;
    logic      content_next;
    tag_mask_t name_hits;
    logic      close_hit;
    logic      is_open;

    assign is_open = (item.data == CHAR_OPEN);

    // Enable mask register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_data;
        end
    end

    // Compare the byte against every remaining candidate tag in parallel.
    always_comb
    begin
        name_hits = '0;
        close_hit = 1'b0;
        for (int t = 0; t < NUM_TAGS; t++)
        begin
            if (cand_reg[t])
            begin
                if (pos_reg == TAG_LEN[t])
                begin
                    if (item.data == CHAR_CLOSE)
                    begin
                        close_hit = 1'b1;
                    end
                end
                else if (pos_reg < TAG_LEN[t] && TAG_TEXT[t][pos_reg] == item.data)
                begin
                    name_hits[t] = 1'b1;
                end
            end
        end
    end

    // Content bytes are copied; the opening bracket closes the item.
    always_comb
    begin
        result.valid = step && content_reg;
        result.data  = is_open ? CHAR_NEWLINE : item.data;
        result.last  = is_open;
    end

    // Next state of the matcher.
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        content_next = content_reg;
        if (step)
        begin
            if (content_reg)
            begin
                if (is_open)
                begin
                    content_next = 1'b0;
                    phase_next   = PHASE_NAME;
                    pos_next     = '0;
                    cand_next    = mask_reg;
                end
            end
            else
            begin
                case (phase_reg)
                    PHASE_NAME:
                    begin
                        if (close_hit)
                        begin
                            phase_next   = PHASE_IDLE;
                            pos_next     = '0;
                            cand_next    = '0;
                            content_next = 1'b1;
                        end
                        else if (name_hits != '0)
                        begin
                            cand_next = name_hits;
                            pos_next  = pos_reg + 3'd1;
                        end
                        else if (is_open)
                        begin
                            phase_next = PHASE_NAME;
                            pos_next   = '0;
                            cand_next  = mask_reg;
                        end
                        else
                        begin
                            phase_next = PHASE_IDLE;
                            pos_next   = '0;
                            cand_next  = '0;
                        end
                    end
                    default:
                    begin
                        pos_next  = '0;
                        if (is_open)
                        begin
                            phase_next = PHASE_NAME;
                            cand_next  = mask_reg;
                        end
                        else
                        begin
                            phase_next = PHASE_IDLE;
                            cand_next  = '0;
                        end
                    end
                endcase
            end
            // The last byte of a document returns the matcher to rest.
            if (item.last)
            begin
                phase_next   = PHASE_IDLE;
                pos_next     = '0;
                cand_next    = '0;
                content_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_IDLE;
            pos_reg     <= '0;
            cand_reg    <= '0;
            content_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            cand_reg    <= cand_next;
            content_reg <= content_next;
        end
    end

    // Copying content and matching a name never overlap.
    `TCE_ASSERT_NEVER(a_content_excl, clk, rst_n, content_reg && phase_reg == PHASE_NAME)
    // Outside a tag name there is no partial match left over.
    `TCE_ASSERT(a_idle_clear, clk, rst_n, phase_reg == PHASE_IDLE |-> pos_reg == '0 && cand_reg == '0)
    // The end of a document leaves the matcher at rest.
    `TCE_ASSERT(a_last_clears, clk, rst_n, step && item.last |=> phase_reg == PHASE_IDLE && !content_reg)
    // An item-closing result always carries the newline.
    `TCE_ASSERT(a_close_newline, clk, rst_n, result.valid && result.last |-> result.data == CHAR_NEWLINE)

endmodule

`default_nettype wire

FILE: sv/tce_out_stage.sv
`default_nettype none

module tce_out_stage
    import tce_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t result,
    output logic         out_take,
    output logic         out_valid,
    input  wire logic    out_ready,
    output byte_t        out_byte,
    output logic         item_last
);

    logic  valid_reg;
    logic  valid_next;
    byte_t data_reg;
    logic  last_reg;

    // The register can take a new result when empty or being drained.
    assign out_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_byte  = data_reg;
    assign item_last = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_take)
        begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_take && result.valid)
        begin
            data_reg <= result.data;
            last_reg <= result.last;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
    import tce_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 9;
    localparam int PHASE_BYTES  = 64;
    localparam int MAX_REPORTS  = 10;

    typedef enum bit {
        ROW_BYTE = 1'b0,
        ROW_MASK = 1'b1
    } row_kind_t;

    // One row of the directed stimulus; typed rows carry their own expected result.
    typedef struct packed {
        row_kind_t kind;
        byte_t     data;
        logic      eoi;
        logic      typed;
        logic      exp_got;
        byte_t     exp_data;
        logic      exp_last;
    } stim_row_t;

    // One expected output transaction.
    typedef struct packed {
        byte_t data;
        logic  last;
    } content_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    tag_mask_t cfg_data;
    logic      in_valid;
    logic      in_ready;
    byte_t     in_byte;
    logic      end_of_input;
    logic      out_valid;
    logic      out_ready;
    byte_t     out_byte;
    logic      item_last;

    tag_content_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .item_last    (item_last)
    );

    // Tag names in enable-mask bit order.
    string tag_names [NUM_TAGS] = '{"A", "IMG", "BASE", "FORM", "LINK", "SCRIPT", "IFRAME"};

    // Predictor state.
    phase_t    pred_phase;
    pos_t      pred_pos;
    tag_mask_t pred_cands;
    bit        pred_copying;
    tag_mask_t pred_mask;

    content_t  pending_content [$];
    stim_row_t directed_rows [$];
    byte_t     doc_data [$];
    bit        doc_eoi [$];

    int send_idle_pct = 9;
    int recv_idle_pct = 51;
    int mismatch_count = 0;
    int stall_cycles = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // A '<' opens a name match against the tags enabled right now.
    task automatic open_tag();
        pred_phase = PHASE_NAME;
        pred_pos   = '0;
        pred_cands = pred_mask;
    endtask

    task automatic close_match();
        pred_phase = PHASE_IDLE;
        pred_pos   = '0;
        pred_cands = '0;
    endtask

    // Advance the matcher by one document byte and report the output it causes.
    task automatic extract_step(input byte_t b, input bit eoi,
                                output bit got, output byte_t ob, output bit ol);
        tag_mask_t nxt;
        bit        closed;
        int        len;
        got    = 1'b0;
        ob     = '0;
        ol     = 1'b0;
        nxt    = '0;
        closed = 1'b0;
        if (pred_copying)
        begin
            got = 1'b1;
            if (b == CHAR_OPEN)
            begin
                ob = CHAR_NEWLINE;
                ol = 1'b1;
                pred_copying = 1'b0;
                open_tag();
            end
            else
            begin
                ob = b;
            end
        end
        else if (pred_phase == PHASE_NAME)
        begin
            for (int t = 0; t < NUM_TAGS; t++)
            begin
                if (pred_cands[t])
                begin
                    len = tag_names[t].len();
                    if (pred_pos == len)
                    begin
                        if (b == CHAR_CLOSE)
                            closed = 1'b1;
                    end
                    else if (pred_pos < len && byte_t'(tag_names[t][pred_pos]) == b)
                    begin
                        nxt[t] = 1'b1;
                    end
                end
            end
            if (closed)
            begin
                close_match();
                pred_copying = 1'b1;
            end
            else if (nxt != '0)
            begin
                pred_cands = nxt;
                pred_pos   = pred_pos + 3'd1;
            end
            else if (b == CHAR_OPEN)
            begin
                open_tag();
            end
            else
            begin
                close_match();
            end
        end
        else if (b == CHAR_OPEN)
        begin
            open_tag();
        end
        else
        begin
            close_match();
        end
        // The last byte of a document leaves the matcher as after reset.
        if (eoi)
        begin
            close_match();
            pred_copying = 1'b0;
        end
    endtask

    // Present one byte, wait for its transaction and record what it should produce.
    task automatic send_byte(input byte_t b, input bit eoi, input bit typed,
                             input bit exp_got, input byte_t exp_data, input bit exp_last);
        bit       got;
        byte_t    ob;
        bit       ol;
        content_t e;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        in_byte      = b;
        end_of_input = eoi;
        do
            @(posedge clk);
        while (!in_ready);
        extract_step(b, eoi, got, ob, ol);
        if (typed)
        begin
            got = exp_got;
            ob  = exp_data;
            ol  = exp_last;
        end
        if (got)
        begin
            e.data = ob;
            e.last = ol;
            pending_content.push_back(e);
        end
        @(negedge clk);
    endtask

    // Write the tag mask once every outstanding byte has worked its way through.
    task automatic set_mask(input tag_mask_t m);
        while (pending_content.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = m;
        @(negedge clk);
        cfg_we    = 1'b0;
        pred_mask = m;
    endtask

    task automatic add_row(input row_kind_t kind, input byte_t data, input bit eoi,
                           input bit typed, input bit exp_got, input byte_t exp_data,
                           input bit exp_last);
        stim_row_t r;
        r.kind     = kind;
        r.data     = data;
        r.eoi      = eoi;
        r.typed    = typed;
        r.exp_got  = exp_got;
        r.exp_data = exp_data;
        r.exp_last = exp_last;
        directed_rows.push_back(r);
    endtask

    // Rows whose results come from the predictor.
    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            add_row(ROW_BYTE, byte_t'(s[k]), 1'b0, 1'b0, 1'b0, '0, 1'b0);
    endtask

    task automatic add_doc(input byte_t b);
        doc_data.push_back(b);
        doc_eoi.push_back($urandom_range(0, 39) == 0);
    endtask

    // Append a random piece of document: mostly complete tags with content,
    // the rest broken tags and loose bytes.
    task automatic add_fragment();
        int    kind;
        int    n;
        string name;
        kind = $urandom_range(0, 9);
        name = tag_names[$urandom_range(0, NUM_TAGS - 1)];
        if (kind <= 6)
        begin
            add_doc(CHAR_OPEN);
            for (int k = 0; k < name.len(); k++)
                add_doc(byte_t'(name[k]));
            add_doc(CHAR_CLOSE);
            n = $urandom_range(0, 5);
            for (int k = 0; k < n; k++)
                add_doc(byte_t'($urandom_range(0, 255)));
        end
        else if (kind <= 8)
        begin
            // Tag cut short, then a wrong byte or a fresh '<'.
            add_doc(CHAR_OPEN);
            n = $urandom_range(0, name.len() - 1);
            for (int k = 0; k < n; k++)
                add_doc(byte_t'(name[k]));
            add_doc(kind == 7 ? byte_t'($urandom_range(0, 255)) : CHAR_OPEN);
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                add_doc(byte_t'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: ready is chosen at each falling edge.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare every output transaction with the oldest expected one.
    always @(posedge clk)
    begin
        content_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_content.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected output: out_byte %02h item_last %0d",
                             out_byte, item_last);
                mismatch_count++;
            end
            else
            begin
                e = pending_content.pop_front();
                if (out_byte !== e.data || item_last !== e.last)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: expected %02h/%0d, got %02h/%0d",
                                 e.data, e.last, out_byte, item_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        tag_mask_t m;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_byte      = '0;
        end_of_input = 1'b0;
        pred_mask    = MASK_RESET;
        pred_copying = 1'b0;
        close_match();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting with every tag enabled by reset.
        add_row(ROW_BYTE, CHAR_OPEN, 1'b0, 1'b1, 1'b0, '0, 1'b0);
        add_text("A>");
        add_row(ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0);
        add_row(ROW_BYTE, CHAR_OPEN, 1'b0, 1'b1, 1'b1, CHAR_NEWLINE, 1'b1);
        // Empty content yields only the newline.
        add_text("IMG>");
        add_row(ROW_BYTE, CHAR_OPEN, 1'b0, 1'b1, 1'b1, CHAR_NEWLINE, 1'b1);
        // Content cut off by the end of the document gets no newline.
        add_text("BASE>");
        add_row(ROW_BYTE, 8'h71, 1'b1, 1'b1, 1'b1, 8'h71, 1'b0);
        // Failed tag whose failing byte opens the next match.
        add_text("<FO<IM");
        // Mask cleared in the middle of a tag: the open match keeps its candidates.
        add_row(ROW_MASK, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        add_text("G>");
        add_row(ROW_BYTE, 8'h7A, 1'b0, 1'b1, 1'b1, 8'h7A, 1'b0);
        add_row(ROW_BYTE, CHAR_OPEN, 1'b0, 1'b1, 1'b1, CHAR_NEWLINE, 1'b1);
        // With an empty mask nothing matches.
        add_text("A>");
        add_row(ROW_BYTE, 8'h77, 1'b0, 1'b1, 1'b0, '0, 1'b0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_MASK)
            begin
                in_valid = 1'b0;
                set_mask(directed_rows[i].data[NUM_TAGS-1:0]);
            end
            else
            begin
                send_byte(directed_rows[i].data, directed_rows[i].eoi,
                          directed_rows[i].typed, directed_rows[i].exp_got,
                          directed_rows[i].exp_data, directed_rows[i].exp_last);
            end
        end
        in_valid = 1'b0;

        // Random documents, one mask setting per phase.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 3)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: m = 7'h7F;
                1: m = 7'h00;
                2: m = 7'h01;
                3: m = 7'h40;
                5: m = 7'h55;
                6: m = 7'h2A;
                8: m = 7'h7F;
                default: m = tag_mask_t'($urandom_range(0, 127));
            endcase
            set_mask(m);

            doc_data.delete();
            doc_eoi.delete();
            while (doc_data.size() < PHASE_BYTES)
                add_fragment();
            foreach (doc_data[i])
                send_byte(doc_data[i], doc_eoi[i], 1'b0, 1'b0, '0, 1'b0);
            in_valid = 1'b0;
        end

        // Drain, then allow for anything still in flight.
        while (pending_content.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_content.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: tag_content_extractor.f
+incdir+sv
sv/tce_pkg.sv
sv/tce_in_stage.sv
sv/tce_matcher.sv
sv/tce_out_stage.sv
sv/tag_content_extractor.sv
test/tb.sv
